// ----- sv/gfa_pkg.sv -----
// Shared types and constants for the finite-field arithmetic unit.
// No dependencies; imported by every module of the block but gfa_ram.
package gfa_pkg;

    localparam int FIELD_BITS  = 8;
    localparam int MAX_ORDER   = 1 << FIELD_BITS;
    localparam int ANT_DEPTH   = 2 * (MAX_ORDER - 1);
    localparam int ANT_AW      = $clog2(ANT_DEPTH);
    localparam int LOG_AW      = FIELD_BITS;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_INV = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_IS_PRIME = 2'd0,
        CFG_ORDER    = 2'd1,
        CFG_POLY     = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PCHK,
        S_PMR,
        S_PSQ
    } seq_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CLEAR,
        B_GEN1,
        B_GEN2
    } bld_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LOGB,
        M_SUM,
        M_ANT,
        M_RED
    } mul_state_t;

    typedef struct packed {
        logic       is_prime;
        logic [8:0] order;
        logic [8:0] poly;
    } field_cfg_t;

    typedef struct packed {
        logic              we;
        logic [ANT_AW-1:0] addr;
        logic [7:0]        data;
    } ant_wr_t;

    typedef struct packed {
        logic              we;
        logic [LOG_AW-1:0] addr;
        logic [7:0]        data;
    } log_wr_t;

    typedef struct packed {
        logic active;
        logic ready;
    } bld_status_t;

    typedef struct packed {
        logic       start;
        logic [7:0] x;
        logic [7:0] y;
    } mul_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } mul_rsp_t;

endpackage

// ----- sv/gfa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/gfa_build.sv -----
// Table builder: clears both tables; for a valid order, fills exp and log
// tables from the field order and reduction polynomial. Depends on gfa_pkg.
module gfa_build import gfa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  field_cfg_t  cfg,
    output ant_wr_t     ant_wr,
    output log_wr_t     log_wr,
    output bld_status_t status
);

    bld_state_t  state_reg, state_next;
    logic [ANT_AW-1:0] cnt_reg, cnt_next;
    logic [7:0]  i_reg, i_next;
    logic [7:0]  x_reg, x_next;
    logic        ready_reg, ready_next;
    logic [7:0]  n;
    logic [8:0]  nx;
    logic        order_ok;
    logic        last_i;

    assign n        = 8'(cfg.order - 9'd1);
    assign order_ok = (cfg.order >= 9'd2) && (cfg.order <= 9'(MAX_ORDER));
    assign last_i   = (i_reg == 8'(n - 8'd1));

    always_comb
    begin
        nx = {x_reg, 1'b0};
        if ((nx & cfg.order) != 9'd0)
        begin
            nx = nx ^ cfg.poly;
        end
    end

    // the order is checked once the clearing pass is over, when the new
    // register value has settled
    always_comb
    begin
        state_next = state_reg;
        if (restart)
        begin
            state_next = B_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:  state_next = B_IDLE;
                B_CLEAR:
                    if (cnt_reg == ANT_AW'(ANT_DEPTH - 1))
                        state_next = order_ok ? B_GEN1 : B_IDLE;
                B_GEN1:  if (last_i) state_next = B_GEN2;
                B_GEN2:  if (last_i) state_next = B_IDLE;
                default: state_next = B_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        ready_next = ready_reg;
        ant_wr     = '0;
        log_wr     = '0;
        if (restart)
        begin
            cnt_next   = '0;
            i_next     = '0;
            x_next     = 8'd1;
            ready_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE: ;
                B_CLEAR:
                begin
                    ant_wr.we   = 1'b1;
                    ant_wr.addr = cnt_reg;
                    log_wr.we   = (cnt_reg < ANT_AW'(MAX_ORDER));
                    log_wr.addr = LOG_AW'(cnt_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
                B_GEN1:
                begin
                    ant_wr.we   = 1'b1;
                    ant_wr.addr = ANT_AW'(i_reg);
                    ant_wr.data = x_reg;
                    log_wr.we   = 1'b1;
                    log_wr.addr = x_reg;
                    log_wr.data = i_reg;
                    i_next      = last_i ? 8'd0 : i_reg + 8'd1;
                    x_next      = last_i ? 8'd1 : nx[7:0];
                end
                B_GEN2:
                begin
                    // second copy of the cycle: rerun the same sequence
                    ant_wr.we   = 1'b1;
                    ant_wr.addr = ANT_AW'({1'b0, n} + {1'b0, i_reg});
                    ant_wr.data = x_reg;
                    i_next      = i_reg + 8'd1;
                    x_next      = nx[7:0];
                    if (last_i) ready_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            cnt_reg   <= '0;
            i_reg     <= '0;
            x_reg     <= 8'd1;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            x_reg     <= x_next;
            ready_reg <= ready_next;
        end
    end

    assign status.active = (state_reg != B_IDLE);
    assign status.ready  = ready_reg;

endmodule

// ----- sv/gfa_mul.sv -----
// Field multiplier: log/antilog lookup in binary mode, shift-subtract
// reduction of the product in prime mode. Depends on gfa_pkg.
module gfa_mul import gfa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  field_cfg_t        cfg,
    input  mul_req_t          req,
    output mul_rsp_t          rsp,
    output logic [LOG_AW-1:0] log_raddr,
    input  logic [7:0]        log_rdata,
    output logic [ANT_AW-1:0] ant_raddr,
    input  logic [7:0]        ant_rdata
);

    mul_state_t  state_reg, state_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  la_reg, la_next;
    logic        zero_reg, zero_next;
    logic [15:0] prod_reg, prod_next;
    logic [2:0]  k_reg, k_next;
    logic        done_reg, done_next;
    logic [7:0]  val_reg, val_next;
    logic [8:0]  idx;
    logic [15:0] shifted;

    assign idx     = {1'b0, la_reg} + {1'b0, log_rdata};
    assign shifted = 16'(cfg.order) << k_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:  if (req.start) state_next = cfg.is_prime ? M_RED : M_LOGB;
            M_LOGB:  state_next = M_SUM;
            M_SUM:   state_next = M_ANT;
            M_ANT:   state_next = M_IDLE;
            M_RED:   if (k_reg == 3'd0) state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_comb
    begin
        y_next    = y_reg;
        la_next   = la_reg;
        zero_next = zero_reg;
        prod_next = prod_reg;
        k_next    = k_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        log_raddr = '0;
        ant_raddr = '0;
        unique case (state_reg)
            M_IDLE:
            begin
                log_raddr = req.x;
                if (req.start)
                begin
                    y_next    = req.y;
                    zero_next = (req.x == 8'd0) || (req.y == 8'd0);
                    prod_next = req.x * req.y;
                    k_next    = 3'd7;
                end
            end
            M_LOGB:
            begin
                log_raddr = y_reg;
                la_next   = log_rdata;
            end
            M_SUM:
            begin
                // sums past the table end read as zero
                if (idx >= 9'(ANT_DEPTH))
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    ant_raddr = ANT_AW'(idx);
                end
            end
            M_ANT:
            begin
                done_next = 1'b1;
                val_next  = zero_reg ? 8'd0 : ant_rdata;
            end
            M_RED:
            begin
                if (prod_reg >= shifted) prod_next = prod_reg - shifted;
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    done_next = 1'b1;
                    val_next  = prod_next[7:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        la_reg   <= la_next;
        zero_reg <= zero_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        val_reg  <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

// ----- sv/galois_field_alu_top.sv -----
// Top level of the finite-field arithmetic unit: configuration registers,
// request sequencer and table memories. Depends on gfa_pkg, gfa_ram,
// gfa_build and gfa_mul.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------
//  request   | start / busy             | op, operand_a, operand_b, exponent
//  result    | done (one-cycle strobe)  | value, zero_inverse, out_of_range
//  config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Add, subtract and rejected requests: result in the cycle after acceptance.
// Multiply: log, log and antilog reads in binary mode, an 8-step reduction
// in prime mode. Power and inverse: per exponent bit one squaring plus one
// multiply for a set bit, so up to 32 * 2 multiplies, all on the shared
// multiplier, with a check state per bit.
// After reset and after every write to a defined register the tables are
// rebuilt: a clearing pass over all 510 exp-table entries, then, when the
// order is valid, two generation passes; busy stays high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module galois_field_alu_top import gfa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [7:0]  operand_a,
    input  logic [7:0]  operand_b,
    input  logic [31:0] exponent,
    output logic        done,
    output logic [7:0]  value,
    output logic        zero_inverse,
    output logic        out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    field_cfg_t  cfg_reg;
    logic        restart;
    bld_status_t bld_st;
    ant_wr_t     ant_wr;
    log_wr_t     log_wr;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;
    logic [LOG_AW-1:0] log_raddr;
    logic [ANT_AW-1:0] ant_raddr;
    logic [7:0]  log_rdata;
    logic [7:0]  ant_rdata;

    seq_state_t  state_reg, state_next;
    logic [7:0]  r_reg, r_next;
    logic [7:0]  b_reg, b_next;
    logic [31:0] e_reg, e_next;
    logic        done_reg, done_next;
    logic [7:0]  val_reg, val_next;
    logic        zinv_reg, zinv_next;
    logic        oor_reg, oor_next;

    logic        accept;
    logic        bad;
    logic [8:0]  sum;
    logic [8:0]  add_mod;
    logic [9:0]  dif;
    logic [9:0]  sub_mod;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index != 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_prime <= 1'b0;
            cfg_reg.order    <= 9'd256;
            cfg_reg.poly     <= 9'd285;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IS_PRIME: cfg_reg.is_prime <= cfg_data[0];
                CFG_ORDER:    cfg_reg.order    <= cfg_data;
                CFG_POLY:     cfg_reg.poly     <= cfg_data;
                default: ;
            endcase
        end
    end

    gfa_build u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .cfg     (cfg_reg),
        .ant_wr  (ant_wr),
        .log_wr  (log_wr),
        .status  (bld_st)
    );

    gfa_ram #(.WIDTH(8), .DEPTH(ANT_DEPTH)) u_ant_ram (
        .clk   (clk),
        .we    (ant_wr.we),
        .waddr (ant_wr.addr),
        .wdata (ant_wr.data),
        .raddr (ant_raddr),
        .rdata (ant_rdata)
    );

    gfa_ram #(.WIDTH(8), .DEPTH(MAX_ORDER)) u_log_ram (
        .clk   (clk),
        .we    (log_wr.we),
        .waddr (log_wr.addr),
        .wdata (log_wr.data),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    gfa_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (mul_req),
        .rsp       (mul_rsp),
        .log_raddr (log_raddr),
        .log_rdata (log_rdata),
        .ant_raddr (ant_raddr),
        .ant_rdata (ant_rdata)
    );

    assign busy   = (state_reg != S_IDLE) || bld_st.active;
    assign accept = start && !busy;

    assign bad = !bld_st.ready || (op > OP_INV)
              || ({1'b0, operand_a} >= cfg_reg.order)
              || ((op <= OP_MUL) && ({1'b0, operand_b} >= cfg_reg.order));

    assign sum     = {1'b0, operand_a} + {1'b0, operand_b};
    assign add_mod = (sum >= cfg_reg.order) ? sum - cfg_reg.order : sum;
    assign dif     = {2'b0, operand_a} + {1'b0, cfg_reg.order} - {2'b0, operand_b};
    assign sub_mod = (dif >= {1'b0, cfg_reg.order}) ? dif - {1'b0, cfg_reg.order} : dif;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && !bad)
                begin
                    if (op == OP_MUL) state_next = S_MUL;
                    else if (op == OP_POW) state_next = S_PCHK;
                    else if (op == OP_INV && operand_a != 8'd0) state_next = S_PCHK;
                end
            S_MUL:  if (mul_rsp.done) state_next = S_IDLE;
            S_PCHK:
                if (e_reg == 32'd0) state_next = S_IDLE;
                else state_next = e_reg[0] ? S_PMR : S_PSQ;
            S_PMR:  if (mul_rsp.done) state_next = S_PSQ;
            S_PSQ:  if (mul_rsp.done) state_next = S_PCHK;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        r_next    = r_reg;
        b_next    = b_reg;
        e_next    = e_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        zinv_next = zinv_reg;
        oor_next  = oor_reg;
        mul_req   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mul_req.x = operand_a;
                mul_req.y = operand_b;
                if (accept)
                begin
                    r_next = 8'd1;
                    b_next = operand_a;
                    e_next = (op == OP_INV) ? 32'(cfg_reg.order - 9'd2) : exponent;
                    val_next  = 8'd0;
                    zinv_next = 1'b0;
                    oor_next  = 1'b0;
                    if (bad)
                    begin
                        done_next = 1'b1;
                        oor_next  = 1'b1;
                    end
                    else
                    begin
                        unique case (op)
                            OP_ADD:
                            begin
                                done_next = 1'b1;
                                val_next  = cfg_reg.is_prime ? add_mod[7:0]
                                                             : operand_a ^ operand_b;
                            end
                            OP_SUB:
                            begin
                                done_next = 1'b1;
                                val_next  = cfg_reg.is_prime ? sub_mod[7:0]
                                                             : operand_a ^ operand_b;
                            end
                            OP_MUL: mul_req.start = 1'b1;
                            OP_POW: ;
                            OP_INV:
                                if (operand_a == 8'd0)
                                begin
                                    done_next = 1'b1;
                                    zinv_next = 1'b1;
                                end
                            default: ;
                        endcase
                    end
                end
            end
            S_MUL:
                if (mul_rsp.done)
                begin
                    done_next = 1'b1;
                    val_next  = mul_rsp.value;
                end
            S_PCHK:
            begin
                mul_req.x = e_reg[0] ? r_reg : b_reg;
                mul_req.y = b_reg;
                if (e_reg == 32'd0)
                begin
                    done_next = 1'b1;
                    val_next  = r_reg;
                end
                else
                begin
                    mul_req.start = 1'b1;
                end
            end
            S_PMR:
            begin
                // hand the squaring straight to the multiplier
                mul_req.x = b_reg;
                mul_req.y = b_reg;
                if (mul_rsp.done)
                begin
                    r_next        = mul_rsp.value;
                    mul_req.start = 1'b1;
                end
            end
            S_PSQ:
                if (mul_rsp.done)
                begin
                    b_next = mul_rsp.value;
                    e_next = e_reg >> 1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        val_reg  <= val_next;
        zinv_reg <= zinv_next;
        oor_reg  <= oor_next;
    end

    assign done         = done_reg;
    assign value        = val_reg;
    assign zero_inverse = zinv_reg;
    assign out_of_range = oor_reg;

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(zero_inverse && out_of_range))
        else $error("zero_inverse and out_of_range both set");

    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bld_st.active |-> busy)
        else $error("request port open during table build");

    a_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (zero_inverse || out_of_range)) |-> (value == 8'd0))
        else $error("flagged result carries nonzero value");

endmodule
